>>> hdl/bgtr_pkg.sv
package bgtr_pkg;

    // default sizes of the stores
    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int BITMAP_BYTES_DEF  = 1024;
    localparam int MAX_GLYPH_DIM_DEF = 8;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // input function codes
    localparam logic [1:0] FUNC_LOAD_GLYPH = 2'd0;
    localparam logic [1:0] FUNC_LOAD_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_SET_CURSOR = 2'd2;
    localparam logic [1:0] FUNC_DRAW_CHAR  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_FIRST_CHAR = 3'd0;
    localparam logic [2:0] REG_LAST_CHAR  = 3'd1;
    localparam logic [2:0] REG_SCALE      = 3'd2;
    localparam logic [2:0] REG_BASE_LINE  = 3'd3;
    localparam logic [2:0] REG_LINE_PITCH = 3'd4;

    // configuration reset values
    localparam logic [7:0] FIRST_CHAR_RST = 8'd32;
    localparam logic [7:0] LAST_CHAR_RST  = 8'd126;
    localparam logic [3:0] SCALE_RST      = 4'd1;
    localparam logic [6:0] BASE_LINE_RST  = 7'd0;
    localparam logic [7:0] LINE_PITCH_RST = 8'd8;

    // effective scale limits
    localparam logic [3:0] SCALE_MIN = 4'd1;
    localparam logic [3:0] SCALE_MAX = 4'd8;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // classified command kinds
    typedef enum logic [2:0] {
        OP_GLYPH_WR,
        OP_BYTE_WR,
        OP_CURSOR,
        OP_NEWLINE,
        OP_DRAW,
        OP_REPORT
    } op_t;

    typedef struct packed {
        logic [7:0] first_char;
        logic [7:0] last_char;
        logic [3:0] scale;
        logic [6:0] base_line;
        logic [7:0] line_pitch;
    } cfg_t;

    typedef struct packed {
        logic [9:0]        offset;
        logic [3:0]        width;
        logic [3:0]        height;
        logic [7:0]        advance;
        logic signed [7:0] x_offset;
        logic signed [7:0] y_offset;
    } glyph_t;

    typedef struct packed {
        op_t         op;
        logic [9:0]  index;
        logic [7:0]  data;
        glyph_t      glyph;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } cmd_t;

endpackage

>>> hdl/bgtr_front.sv
module bgtr_front
    import bgtr_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [9:0]        address,
    input  logic [7:0]        data_byte,
    input  logic [9:0]        bitmap_offset,
    input  logic [3:0]        glyph_width,
    input  logic [3:0]        glyph_height,
    input  logic [7:0]        x_advance,
    input  logic signed [7:0] x_offset,
    input  logic signed [7:0] y_offset,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output cfg_t              cfg,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    cfg_t       cfg_reg;
    logic       accept;
    logic [7:0] char_diff;
    logic       char_in_range;
    logic       glyph_addr_ok;
    logic       byte_addr_ok;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_char <= FIRST_CHAR_RST;
            cfg_reg.last_char  <= LAST_CHAR_RST;
            cfg_reg.scale      <= SCALE_RST;
            cfg_reg.base_line  <= BASE_LINE_RST;
            cfg_reg.line_pitch <= LINE_PITCH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FIRST_CHAR: cfg_reg.first_char <= cfg_data;
                REG_LAST_CHAR:  cfg_reg.last_char  <= cfg_data;
                REG_SCALE:      cfg_reg.scale      <= cfg_data[3:0];
                REG_BASE_LINE:  cfg_reg.base_line  <= cfg_data[6:0];
                REG_LINE_PITCH: cfg_reg.line_pitch <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // range checks
    assign char_diff     = data_byte - cfg_reg.first_char;
    assign char_in_range = (data_byte >= cfg_reg.first_char) &&
                           (data_byte <= cfg_reg.last_char) &&
                           ({1'b0, char_diff} < 9'(GLYPH_ENTRIES));
    assign glyph_addr_ok = ({1'b0, address} < 11'(GLYPH_ENTRIES));
    assign byte_addr_ok  = (17'(address) < 17'(BITMAP_BYTES));

    // classify the transaction into a command
    always_comb
    begin
        q_cmd.op                = OP_REPORT;
        q_cmd.index             = address;
        q_cmd.data              = data_byte;
        q_cmd.glyph.offset      = bitmap_offset;
        q_cmd.glyph.width       = glyph_width;
        q_cmd.glyph.height      = glyph_height;
        q_cmd.glyph.advance     = x_advance;
        q_cmd.glyph.x_offset    = x_offset;
        q_cmd.glyph.y_offset    = y_offset;
        q_cmd.pos_x             = pos_x;
        q_cmd.pos_y             = pos_y;
        q_push                  = 1'b0;
        unique case (func)
            FUNC_LOAD_GLYPH:
            begin
                q_cmd.op = OP_GLYPH_WR;
                q_push   = accept && glyph_addr_ok;
            end
            FUNC_LOAD_BYTE:
            begin
                q_cmd.op = OP_BYTE_WR;
                q_push   = accept && byte_addr_ok;
            end
            FUNC_SET_CURSOR:
            begin
                q_cmd.op = OP_CURSOR;
                q_push   = accept;
            end
            FUNC_DRAW_CHAR:
            begin
                q_push = accept;
                if (data_byte == NEWLINE_CODE)
                begin
                    q_cmd.op = OP_NEWLINE;
                end
                else if (char_in_range)
                begin
                    q_cmd.op    = OP_DRAW;
                    q_cmd.index = 10'(char_diff);
                end
                else
                begin
                    q_cmd.op = OP_REPORT;
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/bgtr_cmd_queue.sv
module bgtr_cmd_queue
    import bgtr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg;
    logic [QA_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == QC_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/bgtr_back.sv
module bgtr_back
    import bgtr_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF,
    parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    output logic               q_pop,
    input  cmd_t               q_cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [3:0]         block_size,
    output logic               pixel_valid,
    output logic               last,
    output logic signed [15:0] cursor_x,
    output logic signed [15:0] cursor_y
);

    localparam int GE_AW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int BB_AW = $clog2(BITMAP_BYTES);
    localparam int PTR_W = (BB_AW > 10) ? BB_AW : 10;
    localparam int XY_W  = (MAX_GLYPH_DIM > 1) ? $clog2(MAX_GLYPH_DIM) : 1;
    localparam logic [PTR_W:0]   BB_LIMIT = (PTR_W + 1)'(BITMAP_BYTES);
    localparam logic [PTR_W-1:0] BB_TOP   = PTR_W'(BITMAP_BYTES - 1);
    localparam logic [3:0]       DIM_MAX  = 4'(MAX_GLYPH_DIM);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GLYPH,
        S_WRAP,
        S_FETCH,
        S_BIT,
        S_FINISH
    } state_t;

    state_t            state_reg;

    // glyph table and bitmap store
    glyph_t            glyph_mem  [GLYPH_ENTRIES];
    logic [7:0]        bitmap_mem [BITMAP_BYTES];
    glyph_t            glyph_rd_reg;
    logic [7:0]        byte_reg;

    // cursor
    logic [15:0]       cursor_x_reg;
    logic [15:0]       cursor_y_reg;
    logic [15:0]       line_start_reg;

    // bitmap walk
    logic [PTR_W-1:0]  addr_reg;
    logic [2:0]        bit_idx_reg;
    logic [XY_W-1:0]   xx_reg;
    logic [XY_W-1:0]   yy_reg;
    logic [XY_W-1:0]   w_last_reg;
    logic [XY_W-1:0]   h_last_reg;
    logic [15:0]       xo_reg;
    logic [15:0]       col_x_reg;
    logic [15:0]       row_y_reg;
    logic              pend_valid_reg;
    logic [15:0]       pend_x_reg;
    logic [15:0]       pend_y_reg;

    // output register
    logic              out_valid_reg;
    logic [15:0]       pixel_x_reg;
    logic [15:0]       pixel_y_reg;
    logic [3:0]        block_size_reg;
    logic              pixel_valid_reg;
    logic              last_reg;
    logic [15:0]       cursor_x_out_reg;
    logic [15:0]       cursor_y_out_reg;

    // combinational helpers
    logic              pop_fire;
    logic              glyph_wr;
    logic              glyph_rd;
    logic              byte_wr;
    logic              fetch;
    logic              bit_step;
    logic              bit_stall;
    logic              push_ok;
    logic              out_load;
    logic [PTR_W-1:0]  ld_addr;
    logic [PTR_W-1:0]  addr_inc;
    logic [3:0]        s_eff;
    logic [3:0]        w_sat;
    logic [3:0]        h_sat;
    logic signed [12:0] xo_prod;
    logic signed [8:0]  yb_sum;
    logic signed [13:0] yo_prod;
    logic [11:0]       adv_prod;
    logic [11:0]       pitch_prod;
    logic [15:0]       xo_start;
    logic [15:0]       yo_start;
    logic              last_col;
    logic              last_row;

    // effective scale
    always_comb
    begin
        if (cfg.scale < SCALE_MIN)
        begin
            s_eff = SCALE_MIN;
        end
        else if (cfg.scale > SCALE_MAX)
        begin
            s_eff = SCALE_MAX;
        end
        else
        begin
            s_eff = cfg.scale;
        end
    end

    // control strobes
    assign push_ok   = !out_valid_reg || out_ready;
    assign pop_fire  = (state_reg == S_IDLE) && !q_empty;
    assign q_pop     = pop_fire;
    assign glyph_wr  = pop_fire && (q_cmd.op == OP_GLYPH_WR);
    assign byte_wr   = pop_fire && (q_cmd.op == OP_BYTE_WR);
    assign glyph_rd  = pop_fire && (q_cmd.op == OP_DRAW);
    assign fetch     = (state_reg == S_FETCH);
    assign bit_stall = byte_reg[7] && pend_valid_reg && !push_ok;
    assign bit_step  = (state_reg == S_BIT) && !bit_stall;
    assign out_load  = (bit_step && byte_reg[7] && pend_valid_reg) ||
                       ((state_reg == S_FINISH) && push_ok);
    assign ld_addr   = PTR_W'(q_cmd.index);
    assign addr_inc  = (addr_reg == BB_TOP) ? '0 : addr_reg + 1'b1;
    assign last_col  = (xx_reg == w_last_reg);
    assign last_row  = (yy_reg == h_last_reg);

    // glyph placement arithmetic
    always_comb
    begin
        w_sat      = (glyph_rd_reg.width > DIM_MAX) ? DIM_MAX : glyph_rd_reg.width;
        h_sat      = (glyph_rd_reg.height > DIM_MAX) ? DIM_MAX : glyph_rd_reg.height;
        xo_prod    = $signed({1'b0, s_eff}) * glyph_rd_reg.x_offset;
        yb_sum     = $signed({2'b00, cfg.base_line}) +
                     $signed({glyph_rd_reg.y_offset[7], glyph_rd_reg.y_offset});
        yo_prod    = $signed({1'b0, s_eff}) * yb_sum;
        adv_prod   = 12'(glyph_rd_reg.advance) * 12'(s_eff);
        pitch_prod = 12'(cfg.line_pitch) * 12'(s_eff);
        xo_start   = cursor_x_reg + {{3{xo_prod[12]}}, xo_prod};
        yo_start   = cursor_y_reg + {{2{yo_prod[13]}}, yo_prod};
    end

    // memories and the bitmap shift byte
    always_ff @(posedge clk)
    begin
        if (glyph_wr)
        begin
            glyph_mem[q_cmd.index[GE_AW-1:0]] <= q_cmd.glyph;
        end
        if (glyph_rd)
        begin
            glyph_rd_reg <= glyph_mem[q_cmd.index[GE_AW-1:0]];
        end
        if (byte_wr)
        begin
            bitmap_mem[ld_addr[BB_AW-1:0]] <= q_cmd.data;
        end
        if (fetch)
        begin
            byte_reg <= bitmap_mem[addr_reg[BB_AW-1:0]];
        end
        else if (bit_step)
        begin
            byte_reg <= {byte_reg[6:0], 1'b0};
        end
    end

    // sequencer, cursor and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            line_start_reg   <= '0;
            addr_reg         <= '0;
            bit_idx_reg      <= '0;
            xx_reg           <= '0;
            yy_reg           <= '0;
            w_last_reg       <= '0;
            h_last_reg       <= '0;
            xo_reg           <= '0;
            col_x_reg        <= '0;
            row_y_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            pend_x_reg       <= '0;
            pend_y_reg       <= '0;
            out_valid_reg    <= 1'b0;
            pixel_x_reg      <= '0;
            pixel_y_reg      <= '0;
            block_size_reg   <= '0;
            pixel_valid_reg  <= 1'b0;
            last_reg         <= 1'b0;
            cursor_x_out_reg <= '0;
            cursor_y_out_reg <= '0;
        end
        else
        begin
            // receiver takes the result and nothing new is loaded
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_fire)
                    begin
                        case (q_cmd.op)
                            OP_CURSOR:
                            begin
                                cursor_x_reg   <= q_cmd.pos_x;
                                line_start_reg <= q_cmd.pos_x;
                                cursor_y_reg   <= q_cmd.pos_y;
                            end
                            OP_NEWLINE:
                            begin
                                cursor_x_reg <= line_start_reg;
                                cursor_y_reg <= cursor_y_reg + 16'(pitch_prod);
                                state_reg    <= S_FINISH;
                            end
                            OP_DRAW:
                            begin
                                state_reg <= S_GLYPH;
                            end
                            OP_REPORT:
                            begin
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_GLYPH:
                begin
                    cursor_x_reg <= cursor_x_reg + 16'(adv_prod);
                    addr_reg     <= PTR_W'(glyph_rd_reg.offset);
                    bit_idx_reg  <= '0;
                    xx_reg       <= '0;
                    yy_reg       <= '0;
                    w_last_reg   <= XY_W'(w_sat - 4'd1);
                    h_last_reg   <= XY_W'(h_sat - 4'd1);
                    xo_reg       <= xo_start;
                    col_x_reg    <= xo_start;
                    row_y_reg    <= yo_start;
                    if ((w_sat == 4'd0) || (h_sat == 4'd0))
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_WRAP;
                    end
                end

                S_WRAP:
                begin
                    // bring the start offset into the store range
                    if ({1'b0, addr_reg} >= BB_LIMIT)
                    begin
                        addr_reg <= PTR_W'({1'b0, addr_reg} - BB_LIMIT);
                    end
                    else
                    begin
                        state_reg <= S_FETCH;
                    end
                end

                S_FETCH:
                begin
                    addr_reg  <= addr_inc;
                    state_reg <= S_BIT;
                end

                S_BIT:
                begin
                    if (bit_step)
                    begin
                        // a new set pixel sends the held one on
                        if (byte_reg[7])
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg    <= 1'b1;
                                pixel_x_reg      <= pend_x_reg;
                                pixel_y_reg      <= pend_y_reg;
                                block_size_reg   <= s_eff;
                                pixel_valid_reg  <= 1'b1;
                                last_reg         <= 1'b0;
                                cursor_x_out_reg <= cursor_x_reg;
                                cursor_y_out_reg <= cursor_y_reg;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_x_reg     <= col_x_reg;
                            pend_y_reg     <= row_y_reg;
                        end
                        bit_idx_reg <= bit_idx_reg + 3'd1;
                        if (last_col)
                        begin
                            xx_reg    <= '0;
                            yy_reg    <= yy_reg + 1'b1;
                            col_x_reg <= xo_reg;
                            row_y_reg <= row_y_reg + 16'(s_eff);
                        end
                        else
                        begin
                            xx_reg    <= xx_reg + 1'b1;
                            col_x_reg <= col_x_reg + 16'(s_eff);
                        end
                        if (last_col && last_row)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (bit_idx_reg == 3'd7)
                        begin
                            state_reg <= S_FETCH;
                        end
                    end
                end

                S_FINISH:
                begin
                    // final result: held pixel or a cursor report
                    if (push_ok)
                    begin
                        out_valid_reg    <= 1'b1;
                        block_size_reg   <= s_eff;
                        last_reg         <= 1'b1;
                        cursor_x_out_reg <= cursor_x_reg;
                        cursor_y_out_reg <= cursor_y_reg;
                        pixel_valid_reg  <= pend_valid_reg;
                        if (pend_valid_reg)
                        begin
                            pixel_x_reg <= pend_x_reg;
                            pixel_y_reg <= pend_y_reg;
                        end
                        else
                        begin
                            pixel_x_reg <= '0;
                            pixel_y_reg <= '0;
                        end
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign block_size  = block_size_reg;
    assign pixel_valid = pixel_valid_reg;
    assign last        = last_reg;
    assign cursor_x    = cursor_x_out_reg;
    assign cursor_y    = cursor_y_out_reg;

endmodule

>>> hdl/bitmap_glyph_text_rasterizer_top.sv
// Bitmap glyph text rasterizer.
// Input channel (in_valid/in_ready) takes one transaction per item: glyph table
// loads, bitmap byte loads, cursor placement and character draws. Output channel
// (out_valid/out_ready) delivers pixel blocks to fill, in bitmap order, with
// last set on the final result of each draw; newlines, characters out of range
// and empty glyphs give one cursor report with pixel_valid low.
// Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle; write only while no draw is in flight.
// An accepted item passes through the command queue; a report then goes
// through the finish state to the output register, while loads and cursor
// placement complete when popped. A draw reads the glyph entry, computes the
// placement, subtracts the store length from an out-of-range offset until it
// fits, then fetches each bitmap byte, walks each glyph bit and issues the
// last result. The walk of one glyph bit per cycle, paused for byte fetches
// and receiver stalls, through the single bitmap read port sets the rate.
// A two-entry command queue decouples intake from the walk.
// Reset clears the cursor, line start, queue and output register and restores
// the register defaults; glyph and bitmap stores hold nothing until loaded.
// When the receiver stalls, the held result stays put and the walk pauses at
// the next set pixel; intake continues until the queue fills.
module bitmap_glyph_text_rasterizer_top
    import bgtr_pkg::*;
#(
    parameter int GLYPH_ENTRIES = GLYPH_ENTRIES_DEF,
    parameter int BITMAP_BYTES  = BITMAP_BYTES_DEF,
    parameter int MAX_GLYPH_DIM = MAX_GLYPH_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [9:0]         address,
    input  logic [7:0]         data_byte,
    input  logic [9:0]         bitmap_offset,
    input  logic [3:0]         glyph_width,
    input  logic [3:0]         glyph_height,
    input  logic [7:0]         x_advance,
    input  logic signed [7:0]  x_offset,
    input  logic signed [7:0]  y_offset,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pixel_x,
    output logic signed [15:0] pixel_y,
    output logic [3:0]         block_size,
    output logic               pixel_valid,
    output logic               last,
    output logic signed [15:0] cursor_x,
    output logic signed [15:0] cursor_y
);

    cfg_t cfg;
    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    cmd_t q_pop_cmd;
    logic q_empty;

    // intake and classification
    bgtr_front #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .BITMAP_BYTES  (BITMAP_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .address       (address),
        .data_byte     (data_byte),
        .bitmap_offset (bitmap_offset),
        .glyph_width   (glyph_width),
        .glyph_height  (glyph_height),
        .x_advance     (x_advance),
        .x_offset      (x_offset),
        .y_offset      (y_offset),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg           (cfg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    // command queue
    bgtr_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // stores, glyph walk and result output
    bgtr_back #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .BITMAP_BYTES  (BITMAP_BYTES),
        .MAX_GLYPH_DIM (MAX_GLYPH_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_cmd       (q_pop_cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .block_size  (block_size),
        .pixel_valid (pixel_valid),
        .last        (last),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y)
    );

endmodule
